// File: rtl/rbst_pkg.sv
// Shared widths and types for the ray/box slab test pipeline.
package rbst_pkg;

    localparam int FRAC_BITS = 16;
    localparam int AXES      = 3;
    localparam int LANES     = 2 * AXES;
    localparam int CW        = 32;
    localparam int HW        = 31;
    localparam int BW        = CW + 2;
    localparam int NW        = CW + 3;
    localparam int UW        = NW - 1;
    localparam int DW        = CW;
    localparam int QB        = 31;
    localparam int RW        = DW + QB;
    localparam int TW        = CW + 2;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic        [HW-1:0] half_t;
    typedef logic signed [NW-1:0] num_t;
    typedef logic        [DW-1:0] den_t;
    typedef logic        [RW-1:0] rem_t;
    typedef logic        [QB-1:0] quo_t;
    typedef logic signed [TW-1:0] tpar_t;

endpackage

// File: rtl/rbst_ray_if.sv
// Ray/box input channel.
interface rbst_ray_if;
    import rbst_pkg::*;
    logic   valid;
    logic   ready;
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
    half_t  half_x;
    half_t  half_y;
    half_t  half_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    center_x, center_y, center_z, half_x, half_y, half_z, input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  center_x, center_y, center_z, half_x, half_y, half_z, output ready);
endinterface

// File: rtl/rbst_hit_if.sv
// Hit result channel.
interface rbst_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

// File: rtl/ray_box_slab_test_unit.sv
// Ray against axis-aligned box slab test, fully pipelined.
// Accepts one ray/box transaction per cycle unless the result output is stalled
// and returns one hit bit per transaction in order. With Q16.16 coordinates the
// pipeline is: input register, bound and numerator stage, divider setup, 31
// restoring-division stages (one quotient bit each, six dividers in parallel),
// slab select and the final reduction. The whole pipeline holds on an output stall.
module ray_box_slab_test_unit
    import rbst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rbst_ray_if.sink   rays,
    rbst_hit_if.source results
);

    logic adv;
    assign adv = !results.valid || results.ready;
    assign rays.ready = adv;

    // stage A: input capture
    logic   a_vld_reg;
    coord_t a_o_reg [AXES];
    coord_t a_d_reg [AXES];
    coord_t a_c_reg [AXES];
    half_t  a_h_reg [AXES];

    // stage B: numerators
    logic              b_vld_reg;
    num_t              b_num_reg [LANES];
    coord_t            b_d_reg   [AXES];
    logic [AXES-1:0]   b_inr_reg;

    // divider stages, index 0 is setup
    logic             dv_vld_reg [QB+1];
    rem_t             dv_rem_reg [QB+1][LANES];
    quo_t             dv_quo_reg [QB+1][LANES];
    den_t             dv_den_reg [QB+1][LANES];
    logic [LANES-1:0] dv_neg_reg [QB+1];
    logic [LANES-1:0] dv_ovf_reg [QB+1];
    logic [AXES-1:0]  dv_dz_reg  [QB+1];
    logic [AXES-1:0]  dv_inr_reg [QB+1];

    // slab select
    logic  s_vld_reg;
    logic  s_miss_reg;
    tpar_t s_ent_reg [AXES];
    tpar_t s_ext_reg [AXES];

    logic out_vld_reg;
    logic hit_reg;

    // stage B combinational
    num_t            b_num_next [LANES];
    logic [AXES-1:0] b_inr_next;
    always_comb
    begin
        logic signed [BW-1:0] lo, hi, o;
        for (int a = 0; a < AXES; a++)
        begin
            o  = BW'(a_o_reg[a]);
            lo = BW'(a_c_reg[a]) - BW'({1'b0, a_h_reg[a]});
            hi = BW'(a_c_reg[a]) + BW'({1'b0, a_h_reg[a]});
            b_num_next[2*a]   = NW'(lo) - NW'(o);
            b_num_next[2*a+1] = NW'(hi) - NW'(o);
            b_inr_next[a]     = (o >= lo) && (o <= hi);
        end
    end

    // divider setup combinational
    rem_t             c_rem_next [LANES];
    den_t             c_den_next [LANES];
    logic [LANES-1:0] c_neg_next;
    logic [LANES-1:0] c_ovf_next;
    logic [AXES-1:0]  c_dz_next;
    always_comb
    begin
        logic [UW-1:0] un;
        coord_t        d;
        for (int l = 0; l < LANES; l++)
        begin
            d  = b_d_reg[l/2];
            un = b_num_reg[l][NW-1] ? UW'(-b_num_reg[l]) : UW'(b_num_reg[l]);
            c_den_next[l] = d[CW-1] ? DW'(-d) : DW'(d);
            c_neg_next[l] = b_num_reg[l][NW-1] ^ d[CW-1];
            // quotient reaches 2^31 exactly when un >= den * 2^(31-F)
            c_ovf_next[l] = RW'(un) >= (RW'(c_den_next[l]) << (QB - FRAC_BITS));
            c_rem_next[l] = RW'(un) << FRAC_BITS;
        end
        for (int a = 0; a < AXES; a++)
        begin
            c_dz_next[a] = (b_d_reg[a] == '0);
        end
    end

    // slab select combinational
    tpar_t s_ent_next [AXES];
    tpar_t s_ext_next [AXES];
    logic  s_miss_next;
    always_comb
    begin
        tpar_t t [LANES];
        tpar_t q;
        for (int l = 0; l < LANES; l++)
        begin
            q = TW'({1'b0, dv_quo_reg[QB][l]});
            if (dv_neg_reg[QB][l])
            begin
                t[l] = dv_ovf_reg[QB][l] ? -(tpar_t'(1) <<< QB) : -q;
            end
            else
            begin
                t[l] = dv_ovf_reg[QB][l] ? (tpar_t'(1) <<< QB) - tpar_t'(1) : q;
            end
        end
        s_miss_next = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            if (dv_dz_reg[QB][a])
            begin
                s_ent_next[a] = -(tpar_t'(1) <<< CW);
                s_ext_next[a] = tpar_t'(1) <<< CW;
                if (!dv_inr_reg[QB][a])
                begin
                    s_miss_next = 1'b1;
                end
            end
            else if (t[2*a] < t[2*a+1])
            begin
                s_ent_next[a] = t[2*a];
                s_ext_next[a] = t[2*a+1];
            end
            else
            begin
                s_ent_next[a] = t[2*a+1];
                s_ext_next[a] = t[2*a];
            end
        end
    end

    logic hit_next;
    always_comb
    begin
        tpar_t t_in, t_out;
        t_in  = s_ent_reg[0];
        t_out = s_ext_reg[0];
        for (int a = 1; a < AXES; a++)
        begin
            if (s_ent_reg[a] > t_in)
            begin
                t_in = s_ent_reg[a];
            end
            if (s_ext_reg[a] < t_out)
            begin
                t_out = s_ext_reg[a];
            end
        end
        hit_next = !s_miss_reg && !(t_out < 0) && !(t_in > t_out);
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            s_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k <= QB; k++)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_vld_reg     <= rays.valid;
            b_vld_reg     <= a_vld_reg;
            dv_vld_reg[0] <= b_vld_reg;
            for (int k = 1; k <= QB; k++)
            begin
                dv_vld_reg[k] <= dv_vld_reg[k-1];
            end
            s_vld_reg   <= dv_vld_reg[QB];
            out_vld_reg <= s_vld_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_o_reg[0] <= rays.origin_x;
            a_o_reg[1] <= rays.origin_y;
            a_o_reg[2] <= rays.origin_z;
            a_d_reg[0] <= rays.dir_x;
            a_d_reg[1] <= rays.dir_y;
            a_d_reg[2] <= rays.dir_z;
            a_c_reg[0] <= rays.center_x;
            a_c_reg[1] <= rays.center_y;
            a_c_reg[2] <= rays.center_z;
            a_h_reg[0] <= rays.half_x;
            a_h_reg[1] <= rays.half_y;
            a_h_reg[2] <= rays.half_z;

            b_num_reg <= b_num_next;
            b_d_reg   <= a_d_reg;
            b_inr_reg <= b_inr_next;

            dv_rem_reg[0] <= c_rem_next;
            dv_den_reg[0] <= c_den_next;
            dv_neg_reg[0] <= c_neg_next;
            dv_ovf_reg[0] <= c_ovf_next;
            dv_dz_reg[0]  <= c_dz_next;
            dv_inr_reg[0] <= b_inr_reg;
            for (int l = 0; l < LANES; l++)
            begin
                dv_quo_reg[0][l] <= '0;
            end

            // one quotient bit per stage, MSB first
            for (int k = 1; k <= QB; k++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    if (dv_rem_reg[k-1][l] >= (RW'(dv_den_reg[k-1][l]) << (QB - k)))
                    begin
                        dv_rem_reg[k][l] <= dv_rem_reg[k-1][l]
                                          - (RW'(dv_den_reg[k-1][l]) << (QB - k));
                        dv_quo_reg[k][l] <= {dv_quo_reg[k-1][l][QB-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[k][l] <= dv_rem_reg[k-1][l];
                        dv_quo_reg[k][l] <= {dv_quo_reg[k-1][l][QB-2:0], 1'b0};
                    end
                end
                dv_den_reg[k] <= dv_den_reg[k-1];
                dv_neg_reg[k] <= dv_neg_reg[k-1];
                dv_ovf_reg[k] <= dv_ovf_reg[k-1];
                dv_dz_reg[k]  <= dv_dz_reg[k-1];
                dv_inr_reg[k] <= dv_inr_reg[k-1];
            end

            s_ent_reg  <= s_ent_next;
            s_ext_reg  <= s_ext_next;
            s_miss_reg <= s_miss_next;
            hit_reg    <= hit_next;
        end
    end

    assign results.valid = out_vld_reg;
    assign results.hit   = hit_reg;

endmodule
